// ===== design/md5_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types and constants of the MD5 digest unit: round constants, shift
// amounts, initial chaining vector and the beat types between the parts.
// ----------------------------------------------------------------------------
package md5_pkg;

  // one message beat as it travels from the front to the core
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } md5_item_t;

  // finished digest handed from the core to the output stage
  typedef struct packed {
    logic         valid;
    logic [127:0] digest;  // byte i of the digest sits in bits 8*i+7 : 8*i
  } md5_digest_t;

  // how the core forms the message words of a compression
  localparam logic [1:0] MODE_DATA = 2'd0;  // plain buffered block
  localparam logic [1:0] MODE_PADA = 2'd1;  // last block, padding and length
  localparam logic [1:0] MODE_PADB = 2'd2;  // padding only, length follows
  localparam logic [1:0] MODE_PADC = 2'd3;  // zeros and length

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;

  // per-round additive constant
  function automatic logic [31:0] round_const(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
      6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
      6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
      6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // left rotate amount, chosen by round group and round index mod 4
  function automatic logic [4:0] rot_amount(input logic [3:0] sel);
    logic [4:0] s;
    case (sel)
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== design/md5_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5_front
// Input side: takes beats, drops idle beats (no byte, no end mark) and queues
// the rest in a four-entry queue that the core drains at its own pace.
// ----------------------------------------------------------------------------
module md5_front
  import md5_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  output logic           full,
  input  wire logic [7:0] in_data_byte,
  input  wire logic      in_has_byte,
  input  wire logic      in_last,
  output logic           q_valid,
  output md5_item_t      q_item,
  input  wire logic      q_take
);

  md5_item_t  mem_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       enq;
  logic       deq;

  assign full    = (cnt_r == 3'd4);
  assign q_valid = (cnt_r != 3'd0);
  assign q_item  = mem_r[rd_ptr_r];

  // beats that carry neither a byte nor an end mark change nothing
  assign enq = push && !full && (in_has_byte || in_last);
  assign deq = q_take && q_valid;

  always_comb begin
    wr_ptr_nxt = enq ? wr_ptr_r + 2'd1 : wr_ptr_r;
    rd_ptr_nxt = deq ? rd_ptr_r + 2'd1 : rd_ptr_r;
    cnt_nxt    = cnt_r + {2'b00, enq} - {2'b00, deq};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (enq) begin
      mem_r[wr_ptr_r] <= '{data_byte: in_data_byte, has_byte: in_has_byte,
                           last: in_last};
    end
  end

endmodule
`default_nettype wire

// ===== design/md5_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5_core
// Back side: gathers bytes into the 16-word block buffer, runs one MD5 round
// per cycle, forms padding and length on the fly and hands off the digest.
// ----------------------------------------------------------------------------
module md5_core
  import md5_pkg::*;
#(
  parameter int LENGTH_COUNTER_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  input  wire md5_item_t q_item,
  output logic       q_take,
  output md5_digest_t dig,
  input  wire logic  dig_ready
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ROUND = 2'd1;
  localparam logic [1:0] S_FIN   = 2'd2;
  localparam logic [1:0] S_SEND  = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic        pend_last_r, pend_last_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [LENGTH_COUNTER_BITS-1:0] count_r, count_nxt, count_inc;
  logic [31:0] chain_r [4];
  logic [31:0] chain_nxt [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt;
  logic [31:0] buf_r [16];
  logic        buf_we;
  logic        start;

  // round datapath signals
  logic [31:0] f;
  logic [3:0]  w;
  logic [31:0] m_word;
  logic [31:0] sum;
  logic [63:0] rot_wide;
  logic [4:0]  s;
  logic [63:0] bit_len;
  logic [5:0]  pos;

  assign pos     = count_r[5:0];
  assign bit_len = 64'({count_r, 3'b000});
  assign count_inc = count_r + LENGTH_COUNTER_BITS'(1);

  // message word: buffer bytes, padding byte, zeros or length, per mode
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic [5:0] k;
      logic [7:0] bv;
      k  = {w, 2'(b)};
      bv = buf_r[w][8*b +: 8];
      case (mode_r)
        MODE_DATA: m_word[8*b +: 8] = bv;
        MODE_PADA: begin
          if (k < pos)            m_word[8*b +: 8] = bv;
          else if (k == pos)      m_word[8*b +: 8] = PAD_BYTE;
          else if (k >= LEN_START) m_word[8*b +: 8] = bit_len[8*k[2:0] +: 8];
          else                    m_word[8*b +: 8] = 8'h00;
        end
        MODE_PADB: begin
          if (k < pos)       m_word[8*b +: 8] = bv;
          else if (k == pos) m_word[8*b +: 8] = PAD_BYTE;
          else               m_word[8*b +: 8] = 8'h00;
        end
        MODE_PADC: begin
          if (k >= LEN_START) m_word[8*b +: 8] = bit_len[8*k[2:0] +: 8];
          else                m_word[8*b +: 8] = 8'h00;
        end
        default: m_word[8*b +: 8] = bv;
      endcase
    end
  end

  // one MD5 round: boolean function, word select, add, rotate
  always_comb begin
    case (rnd_r[5:4])
      2'd0: begin
        f = (b_r & c_r) | (~b_r & d_r);
        w = rnd_r[3:0];
      end
      2'd1: begin
        f = (b_r & d_r) | (c_r & ~d_r);
        w = 4'(rnd_r[3:0] * 4'd5 + 4'd1);
      end
      2'd2: begin
        f = b_r ^ c_r ^ d_r;
        w = 4'(rnd_r[3:0] * 4'd3 + 4'd5);
      end
      default: begin
        f = c_r ^ (b_r | ~d_r);
        w = 4'(rnd_r[3:0] * 4'd7);
      end
    endcase
    s        = rot_amount({rnd_r[5:4], rnd_r[1:0]});
    sum      = a_r + f + round_const(rnd_r) + m_word;
    rot_wide = {sum, sum} << s;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    pend_last_nxt = pend_last_r;
    rnd_nxt       = rnd_r;
    count_nxt     = count_r;
    chain_nxt     = chain_r;
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r;
    q_take = 1'b0;
    buf_we = 1'b0;
    start  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_take = 1'b1;
          if (q_item.has_byte) begin
            buf_we    = 1'b1;
            count_nxt = count_inc;
            if (pos == 6'd63) begin
              start         = 1'b1;
              mode_nxt      = MODE_DATA;
              pend_last_nxt = q_item.last;
            end else if (q_item.last) begin
              start    = 1'b1;
              mode_nxt = (count_inc[5:0] < LEN_START) ? MODE_PADA : MODE_PADB;
            end
          end else if (q_item.last) begin
            start    = 1'b1;
            mode_nxt = (pos < LEN_START) ? MODE_PADA : MODE_PADB;
          end
        end
      end
      S_ROUND: begin
        a_nxt   = d_r;
        d_nxt   = c_r;
        c_nxt   = b_r;
        b_nxt   = b_r + rot_wide[63:32];
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) state_nxt = S_FIN;
      end
      S_FIN: begin
        chain_nxt[0] = chain_r[0] + a_r;
        chain_nxt[1] = chain_r[1] + b_r;
        chain_nxt[2] = chain_r[2] + c_r;
        chain_nxt[3] = chain_r[3] + d_r;
        case (mode_r)
          MODE_DATA: begin
            if (pend_last_r) begin
              // full block ended the message: fill position is zero
              start         = 1'b1;
              mode_nxt      = MODE_PADA;
              pend_last_nxt = 1'b0;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          MODE_PADB: begin
            start    = 1'b1;
            mode_nxt = MODE_PADC;
          end
          default: state_nxt = S_SEND;
        endcase
      end
      S_SEND: begin
        if (dig_ready) begin
          chain_nxt[0] = IV0;
          chain_nxt[1] = IV1;
          chain_nxt[2] = IV2;
          chain_nxt[3] = IV3;
          count_nxt    = '0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (start) begin
      state_nxt = S_ROUND;
      rnd_nxt   = '0;
      a_nxt = chain_nxt[0];
      b_nxt = chain_nxt[1];
      c_nxt = chain_nxt[2];
      d_nxt = chain_nxt[3];
    end
  end

  assign dig.valid  = (state_r == S_SEND);
  assign dig.digest = {chain_r[3], chain_r[2], chain_r[1], chain_r[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_DATA;
      pend_last_r <= 1'b0;
      rnd_r       <= '0;
      count_r     <= '0;
      chain_r[0]  <= IV0;
      chain_r[1]  <= IV1;
      chain_r[2]  <= IV2;
      chain_r[3]  <= IV3;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      pend_last_r <= pend_last_nxt;
      rnd_r       <= rnd_nxt;
      count_r     <= count_nxt;
      chain_r     <= chain_nxt;
    end
  end

  // working variables and block buffer
  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
    if (buf_we) buf_r[pos[5:2]][8*pos[1:0] +: 8] <= q_item.data_byte;
  end

endmodule
`default_nettype wire

// ===== design/md5_out.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5_out
// Result side: holds one digest and plays it out as raw bytes or lower-case
// hex characters; also keeps the output format register.
// ----------------------------------------------------------------------------
module md5_out
  import md5_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,
  input  wire md5_digest_t dig,
  output logic            dig_ready,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_value,
  output logic            out_last_out
);

  logic         hex_r;
  logic         hex_mode_r;
  logic         busy_r, busy_nxt;
  logic [4:0]   idx_r, idx_nxt;
  logic [127:0] digest_r;
  logic [7:0]   cur_byte;
  logic [3:0]   nib;
  logic         take;
  logic         done;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'(8'h30 + n) : 8'(8'h57 + n);
  endfunction

  assign empty     = !busy_r;
  assign dig_ready = !busy_r;
  assign take      = dig.valid && !busy_r;

  // pick the current byte or nibble
  always_comb begin
    cur_byte = hex_mode_r ? digest_r[8*idx_r[4:1] +: 8] : digest_r[8*idx_r[3:0] +: 8];
    nib      = idx_r[0] ? cur_byte[3:0] : cur_byte[7:4];
    out_value    = hex_mode_r ? hex_char(nib) : cur_byte;
    out_last_out = hex_mode_r ? (idx_r == 5'd31) : (idx_r == 5'd15);
    done         = pop && busy_r && out_last_out;
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (take) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (pop && busy_r) begin
      idx_nxt = idx_r + 5'd1;
      if (done) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hex_r  <= 1'b1;
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (cfg_we) hex_r <= cfg_wdata;
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // digest and format latched per message
  always_ff @(posedge clk) begin
    if (take) begin
      digest_r   <= dig.digest;
      hex_mode_r <= hex_r;
    end
  end

endmodule
`default_nettype wire

// ===== design/md5_digest_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5_digest_unit
// Streaming MD5 digest: message bytes in, 16 digest bytes or 32 hex chars out.
// ----------------------------------------------------------------------------
// Message bytes enter one per beat through a four-entry queue and are taken
// into the block buffer at one per cycle while the core is idle. Each
// completed 64-byte block stalls intake while the single round unit runs its
// 64 rounds and the chaining update. A beat marked last adds one or two
// padding compressions and then hands the digest to the output stage, which
// plays it out one beat per cycle in which pop is high while the next message
// is already being absorbed; a second finished digest waits in the core until
// the first is fully popped. cfg_wdata, written with cfg_we, selects hex (1) or
// raw (0) output; the setting is sampled when a digest is handed over.
// ----------------------------------------------------------------------------
module md5_digest_unit
  import md5_pkg::*;
#(
  parameter int LENGTH_COUNTER_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_has_byte,
  input  wire logic       in_last,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_value,
  output logic            out_last_out,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata
);

  logic        q_valid;
  md5_item_t   q_item;
  logic        q_take;
  md5_digest_t dig;
  logic        dig_ready;

  md5_front u_front (
    .clk, .rst_n, .push, .full, .in_data_byte, .in_has_byte, .in_last,
    .q_valid, .q_item, .q_take
  );

  md5_core #(.LENGTH_COUNTER_BITS(LENGTH_COUNTER_BITS)) u_core (
    .clk, .rst_n, .q_valid, .q_item, .q_take, .dig, .dig_ready
  );

  md5_out u_out (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .dig, .dig_ready, .empty, .pop,
    .out_value, .out_last_out
  );

endmodule
`default_nettype wire
